// File: hdl/vertex_triple_deduplicator_core_assert.svh
// ----------------------------------------------------------------------------
// Vertex triple deduplicator assertion macros
// Shorthand for clocked assertions with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRIPLE_DEDUPLICATOR_CORE_ASSERT_SVH
`define VERTEX_TRIPLE_DEDUPLICATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define VTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vtd_pkg.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator package
// Shared sizes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtd_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int INDEX_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS    = 3 * INDEX_BITS;

    // Port field widths
    localparam int FIELD_BITS  = 16;
    localparam int ELEM_BITS   = 10;

    // Controller to datapath commands
    typedef struct packed {
        logic start;      // latch a new corner and restart the scan
        logic scan_step;  // advance the search by one entry
        logic load_out;   // move the result into the output register
    } vtd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // compared entry matches the corner
        logic miss;       // all entries examined without a match
        logic out_free;   // output register can take a word this cycle
    } vtd_status_t;

endpackage

// File: hdl/vtd_corner_if.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator input channel
// Valid/ready channel carrying one face corner per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtd_corner_if;

    logic                             valid;
    logic                             ready;
    logic [vtd_pkg::FIELD_BITS-1:0]   position_index;
    logic [vtd_pkg::FIELD_BITS-1:0]   texcoord_index;
    logic [vtd_pkg::FIELD_BITS-1:0]   normal_index;

    modport source (
        output valid, position_index, texcoord_index, normal_index,
        input  ready
    );

    modport sink (
        input  valid, position_index, texcoord_index, normal_index,
        output ready
    );

endinterface

// File: hdl/vtd_element_if.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator output channel
// Valid/ready channel carrying one element index result per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtd_element_if;

    logic                           valid;
    logic                           ready;
    logic [vtd_pkg::ELEM_BITS-1:0]  element_index;
    logic                           is_new;
    logic                           table_full;

    modport source (
        output valid, element_index, is_new, table_full,
        input  ready
    );

    modport sink (
        input  valid, element_index, is_new, table_full,
        output ready
    );

endinterface

// File: hdl/vtd_ctrl.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator controller
// Sequences accept, table scan and result hand-off for one corner at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vtd_pkg::vtd_status_t  status,
    output vtd_pkg::vtd_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a corner only when no search is in flight
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.start      = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit || status.miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/vtd_datapath.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator datapath
// Triple table memory, scan pointers, compare, insert and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    vtd_corner_if.sink             corner,
    vtd_element_if.source          element,
    input  vtd_pkg::vtd_cmd_t      cmd,
    output vtd_pkg::vtd_status_t   status
);

    // Triple table, one read port and one write port
    logic [vtd_pkg::KEY_BITS-1:0]   mem [vtd_pkg::TABLE_DEPTH];

    logic [vtd_pkg::KEY_BITS-1:0]   key_reg;
    logic [vtd_pkg::KEY_BITS-1:0]   rd_data_reg;
    logic [vtd_pkg::COUNT_BITS-1:0] issue_idx_reg;
    logic [vtd_pkg::COUNT_BITS-1:0] cmp_idx_reg;
    logic                           cmp_vld_reg;
    logic [vtd_pkg::COUNT_BITS-1:0] count_reg;

    logic [vtd_pkg::ELEM_BITS-1:0]  res_index_reg;
    logic                           res_new_reg;
    logic                           res_full_reg;

    logic                           out_valid_reg;
    logic [vtd_pkg::ELEM_BITS-1:0]  out_index_reg;
    logic                           out_new_reg;
    logic                           out_full_reg;

    logic [vtd_pkg::KEY_BITS-1:0]   key_in;
    logic                           hit;
    logic                           issue_ok;
    logic                           miss;
    logic                           full;
    logic                           resolve;
    logic                           mem_we;

    // Keep the low INDEX_BITS of each field (here the whole 16-bit field)
    assign key_in = {corner.position_index[vtd_pkg::INDEX_BITS-1:0],
                     corner.texcoord_index[vtd_pkg::INDEX_BITS-1:0],
                     corner.normal_index[vtd_pkg::INDEX_BITS-1:0]};

    // Compare stage and scan bounds
    assign hit      = cmp_vld_reg && (rd_data_reg == key_reg);
    assign issue_ok = (issue_idx_reg < count_reg);
    assign miss     = !hit && !issue_ok;
    assign full     = (count_reg == vtd_pkg::COUNT_BITS'(vtd_pkg::TABLE_DEPTH));
    assign resolve  = cmd.scan_step && (hit || miss);
    assign mem_we   = cmd.scan_step && miss && !full;

    assign status.hit      = hit;
    assign status.miss     = miss;
    assign status.out_free = !out_valid_reg || element.ready;

    // Table write on insert, registered read at the issue pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[vtd_pkg::ADDR_BITS-1:0]] <= key_reg;
        end
        rd_data_reg <= mem[issue_idx_reg[vtd_pkg::ADDR_BITS-1:0]];
    end

    // Scan control and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                issue_idx_reg <= '0;
                cmp_vld_reg   <= 1'b0;
            end
            else if (cmd.scan_step && !resolve)
            begin
                cmp_idx_reg   <= issue_idx_reg;
                cmp_vld_reg   <= 1'b1;
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Latch the corner and the search result
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key_in;
        end
        if (resolve)
        begin
            if (hit)
            begin
                res_index_reg <= cmp_idx_reg[vtd_pkg::ELEM_BITS-1:0];
                res_new_reg   <= 1'b0;
                res_full_reg  <= 1'b0;
            end
            else if (full)
            begin
                res_index_reg <= '0;
                res_new_reg   <= 1'b0;
                res_full_reg  <= 1'b1;
            end
            else
            begin
                res_index_reg <= count_reg[vtd_pkg::ELEM_BITS-1:0];
                res_new_reg   <= 1'b1;
                res_full_reg  <= 1'b0;
            end
        end
    end

    // Output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (element.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_index_reg <= res_index_reg;
            out_new_reg   <= res_new_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign element.valid         = out_valid_reg;
    assign element.element_index = out_index_reg;
    assign element.is_new        = out_new_reg;
    assign element.table_full    = out_full_reg;

endmodule

// File: hdl/vertex_triple_deduplicator_core.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator core
// Maps each face corner to the index of its unique vertex triple.
// ----------------------------------------------------------------------------
// Each corner (position, texcoord, normal index) is looked up in a table of
// unique triples built since reset, one stored entry per clock through the
// table memory's single read port. A hit returns the entry index; a miss
// appends the triple and returns its new index with is_new set; a miss with
// all TABLE_DEPTH entries used returns table_full and stores nothing.
// The search reads entries in insertion order and stops at the first match,
// or once every stored entry has been compared without one. One corner is
// in flight at a time; the finished word waits in an output register while
// the next corner is taken. The table needs no clearing after reset: a fill
// count bounds the search.
`timescale 1ns / 1ps

module vertex_triple_deduplicator_core (
    input  logic           clk,
    input  logic           rst_n,
    vtd_corner_if.sink     corner,
    vtd_element_if.source  element
);

    vtd_pkg::vtd_cmd_t     cmd;
    vtd_pkg::vtd_status_t  status;
    logic                  in_ready;

    assign corner.ready = in_ready;

    // Sequencer
    vtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (corner.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, compare and output register
    vtd_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .corner  (corner),
        .element (element),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// File: hdl/vtd_checker.sv
// ----------------------------------------------------------------------------
// Vertex triple deduplicator port checker
// Watches the top-level channels and flags illegal result sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_triple_deduplicator_core_assert.svh"

module vtd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [vtd_pkg::ELEM_BITS-1:0]  element_index,
    input  logic                           is_new,
    input  logic                           table_full
);

    // Hold a stalled result word
    `VTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // One corner in flight: no accept in the cycle after an accept
    `VTD_ASSERT_NEXT(a_single_flight, clk, rst_n, in_valid && in_ready, !in_ready, "back-to-back accept")

    // A word is never both inserted and rejected
    `VTD_ASSERT_SAME(a_new_xor_full, clk, rst_n, out_valid, !(is_new && table_full), "new and full together")

    // A rejected corner carries index zero
    `VTD_ASSERT_SAME(a_full_index, clk, rst_n, out_valid && table_full, element_index == '0, "full with nonzero index")

endmodule

bind vertex_triple_deduplicator_core vtd_checker u_vtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (corner.valid),
    .in_ready      (corner.ready),
    .out_valid     (element.valid),
    .out_ready     (element.ready),
    .element_index (element.element_index),
    .is_new        (element.is_new),
    .table_full    (element.table_full)
);

// File: tb/vertex_dedup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex deduplication checker
// Watches the corner and element channels of the deduplicator. Keeps its own
// table of unique triples, works out the element word for every accepted
// corner and compares each accepted element word with the oldest one due.
// ----------------------------------------------------------------------------

module vertex_dedup_checker
    import vtd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    vtd_corner_if  corner,
    vtd_element_if element,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        logic [ELEM_BITS-1:0] element_index;
        logic                 is_new;
        logic                 table_full;
    } element_word_t;

    logic [KEY_BITS-1:0] known_triples [TABLE_DEPTH];
    int unsigned         known_count;
    element_word_t       due_words [$];

    // Search the table in insertion order; append on a miss if there is room
    function automatic element_word_t lookup_or_insert(input logic [KEY_BITS-1:0] key);
        element_word_t word;
        word = '0;
        for (int i = 0; i < known_count; i++)
        begin
            if (known_triples[i] == key)
            begin
                word.element_index = ELEM_BITS'(i);
                return word;
            end
        end
        if (known_count >= TABLE_DEPTH)
        begin
            word.table_full = 1'b1;
            return word;
        end
        known_triples[known_count] = key;
        word.element_index = ELEM_BITS'(known_count);
        word.is_new        = 1'b1;
        known_count++;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        element_word_t due;
        logic [KEY_BITS-1:0] key;
        if (!rst_n)
        begin
            known_count = 0;
            due_words.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // Check an outgoing word before taking the next corner
            if (element.valid && element.ready)
            begin
                if (due_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected element word: index %0d is_new %0b full %0b",
                             $time, element.element_index, element.is_new,
                             element.table_full);
                end
                else
                begin
                    due = due_words.pop_front();
                    if (element.element_index !== due.element_index)
                    begin
                        fail_count++;
                        $display("%0t: element_index expected %0d got %0d",
                                 $time, due.element_index, element.element_index);
                    end
                    if (element.is_new !== due.is_new)
                    begin
                        fail_count++;
                        $display("%0t: is_new expected %0b got %0b",
                                 $time, due.is_new, element.is_new);
                    end
                    if (element.table_full !== due.table_full)
                    begin
                        fail_count++;
                        $display("%0t: table_full expected %0b got %0b",
                                 $time, due.table_full, element.table_full);
                    end
                end
            end

            // Predict the word for an accepted corner
            if (corner.valid && corner.ready)
            begin
                key = {corner.position_index[INDEX_BITS-1:0],
                       corner.texcoord_index[INDEX_BITS-1:0],
                       corner.normal_index[INDEX_BITS-1:0]};
                due_words = {due_words, lookup_or_insert(key)};
            end
            pending = due_words.size();
        end
    end

endmodule

// File: tb/tb_vertex_triple_deduplicator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex triple deduplicator testbench
// Drives edge-case corners, then a random mix of repeated, near-miss and
// fresh triples under varying source gaps and sink stalls, with one long
// sink hold-off. The checker beside the core predicts and compares every
// element word.
// ----------------------------------------------------------------------------

module tb_vertex_triple_deduplicator_core;

    import vtd_pkg::*;

    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 64;
    localparam int PHASE_ITEMS  = 140;

    // Field extremes, single-bit differences per field, swapped fields, repeats
    localparam logic [KEY_BITS-1:0] EDGE_TRIPLES [18] = '{
        48'h0000_0000_0000, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF,
        48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000,
        48'h0000_0000_8000, 48'h0000_8000_0000, 48'h8000_0000_0000,
        48'hFFFF_FFFF_FFFE, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
        48'h0001_0000_0000, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555,
        48'hAAAA_5555_AAAA, 48'h7FFF_FFFF_FFFF, 48'h0000_0000_0000
    };
    localparam int SRC_IDLE_BY_PHASE  [4] = '{0, 57, 0, 25};
    localparam int SINK_STALL_BY_PHASE[4] = '{0, 0, 57, 25};

    logic clk;
    logic rst_n;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic hold_start     = 1'b0;
    logic hold_served    = 1'b0;
    int   hold_left      = 0;
    int   fail_count;
    int   pending;

    // Triples the core should hold, in insertion order
    logic [KEY_BITS-1:0] stored_triples [$];

    vtd_corner_if  corner_ch();
    vtd_element_if element_ch();

    vertex_triple_deduplicator_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .corner  (corner_ch),
        .element (element_ch)
    );

    vertex_dedup_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .corner     (corner_ch),
        .element    (element_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sink: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start && !hold_served)
        begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            element_ch.ready <= 1'b0;
        end
        else
            element_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic bit is_stored(input logic [KEY_BITS-1:0] key);
        foreach (stored_triples[i])
            if (stored_triples[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [KEY_BITS-1:0] unseen_triple();
        logic [KEY_BITS-1:0] key;
        do
            key = KEY_BITS'({$urandom, $urandom});
        while (is_stored(key));
        return key;
    endfunction

    // Offer one corner word after a random gap and wait for it to be taken
    task automatic offer_triple(input logic [KEY_BITS-1:0] key);
        if (!is_stored(key) && stored_triples.size() < TABLE_DEPTH)
            stored_triples = {stored_triples, key};
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            corner_ch.valid          <= 1'b0;
            corner_ch.position_index <= FIELD_BITS'($urandom);
            corner_ch.texcoord_index <= FIELD_BITS'($urandom);
            corner_ch.normal_index   <= FIELD_BITS'($urandom);
        end
        @(negedge clk);
        corner_ch.valid          <= 1'b1;
        corner_ch.position_index <= key[3*INDEX_BITS-1 -: INDEX_BITS];
        corner_ch.texcoord_index <= key[2*INDEX_BITS-1 -: INDEX_BITS];
        corner_ch.normal_index   <= key[INDEX_BITS-1 -: INDEX_BITS];
        do
            @(posedge clk);
        while (!corner_ch.ready);
    endtask

    // Mostly repeats of stored triples, some one-bit near misses, some fresh
    task automatic offer_mixed_triple();
        int                  roll;
        int                  bit_pos;
        logic [KEY_BITS-1:0] key;
        roll = $urandom_range(99);
        if (stored_triples.size() > 0 && roll < 70)
        begin
            key = stored_triples[$urandom_range(stored_triples.size() - 1)];
            if (roll >= 55)
            begin
                bit_pos      = $urandom_range(KEY_BITS - 1);
                key[bit_pos] = ~key[bit_pos];
            end
        end
        else
            key = unseen_triple();
        offer_triple(key);
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        corner_ch.valid          = 1'b0;
        corner_ch.position_index = '0;
        corner_ch.texcoord_index = '0;
        corner_ch.normal_index   = '0;
        element_ch.ready         = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Edge cases, no idling
        foreach (EDGE_TRIPLES[i])
            offer_triple(EDGE_TRIPLES[i]);

        // Random mix through each idling phase; long sink hold-off in the first
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = SRC_IDLE_BY_PHASE[phase];
            sink_stall_pct = SINK_STALL_BY_PHASE[phase];
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 0 && k == 70)
                    hold_start = 1'b1;
                offer_mixed_triple();
            end
        end

        // Drop valid, drain, then watch for stray words
        @(negedge clk);
        corner_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/vtd_pkg.sv
hdl/vtd_corner_if.sv
hdl/vtd_element_if.sv
hdl/vtd_ctrl.sv
hdl/vtd_datapath.sv
hdl/vertex_triple_deduplicator_core.sv
hdl/vtd_checker.sv
tb/vertex_dedup_checker.sv
tb/tb_vertex_triple_deduplicator_core.sv
